FILE: rtl/otl_pkg.sv
// Shared types, constants and the tangent-to-angle table builder for the atan2 unit.
package otl_pkg;

   localparam int COORD_BITS = 32;
   localparam int TABLE_HALF = 512;
   localparam int HALF_SHIFT = $clog2(TABLE_HALF);
   localparam int ROM_SIZE   = 2 * TABLE_HALF + 1;
   localparam int IDX_W      = $clog2(ROM_SIZE);
   localparam int DIV_W      = COORD_BITS - HALF_SHIFT + 1;
   localparam int MARK_COUNT = 128;
   localparam int ANGLE_W    = 16;
   // prep stage, one stage per cell, index stage, table read, base add
   localparam int LATENCY    = COORD_BITS + 4;

   localparam logic [1:0] QUAD_EAST  = 2'd0;
   localparam logic [1:0] QUAD_NORTH = 2'd1;
   localparam logic [1:0] QUAD_WEST  = 2'd2;
   localparam logic [1:0] QUAD_SOUTH = 2'd3;

   localparam logic [63:0] PI_Q62  = 64'hC90FDAA22168C234;
   localparam logic [63:0] ONE_Q62 = 64'h4000000000000000;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] coord_x;
      logic signed [COORD_BITS-1:0] coord_y;
   } req_type;

   typedef struct packed {
      logic [ANGLE_W-1:0] angle;
      logic               divide_by_zero;
      logic               index_clamped;
   } rsp_type;

   typedef struct packed {
      logic [1:0] quad;
      logic       neg;
      logic       zero;
   } meta_type;

   typedef struct packed {
      logic                  valid;
      meta_type              meta;
      logic [DIV_W-1:0]      rem;
      logic [DIV_W-1:0]      divisor;
      logic [COORD_BITS-1:0] dividend;
      logic [COORD_BITS-1:0] quot;
   } cell_type;

   typedef logic [ANGLE_W-1:0] rom_type [ROM_SIZE];

   function automatic logic [63:0] mul_q62(logic [63:0] a, logic [63:0] b);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      return p[125:62];
   endfunction

   // shift-subtract quotient for table generation; divisor stays below 2^63
   function automatic logic [63:0] udiv64(logic [63:0] a, logic [63:0] b);
      logic [63:0] q, r;
      q = '0;
      r = '0;
      for (int i = 63; i >= 0; i--) begin
         r = {r[62:0], a[i]};
         if (r >= b) begin
            r    = r - b;
            q[i] = 1'b1;
         end
      end
      return q;
   endfunction

   // floor(TABLE_HALF * tan(i*pi/512)), limited to TABLE_HALF
   function automatic logic [63:0] scaled_tan(int i);
      logic [63:0] th, th2, t, s, c, n, dv;
      if (i == 0) return 64'd0;
      if (i >= MARK_COUNT) return 64'(TABLE_HALF);
      th  = (PI_Q62 >> 9) * 64'(i);
      th2 = mul_q62(th, th);
      t = th;
      s = th;
      for (int k = 1; k <= 14; k++) begin
         dv = 64'((2 * k) * (2 * k + 1));
         t = udiv64(mul_q62(t, th2), dv);
         if (k % 2 == 1) s = s - t; else s = s + t;
      end
      t = ONE_Q62;
      c = ONE_Q62;
      for (int k = 1; k <= 14; k++) begin
         dv = 64'((2 * k - 1) * (2 * k));
         t = udiv64(mul_q62(t, th2), dv);
         if (k % 2 == 1) c = c - t; else c = c + t;
      end
      c = c >> 12;
      if (c == 64'd0) return 64'(TABLE_HALF);
      n = udiv64(64'(TABLE_HALF) * (s >> 12), c);
      return (n > 64'(TABLE_HALF)) ? 64'(TABLE_HALF) : n;
   endfunction

   function automatic rom_type build_rom();
      rom_type     rom;
      logic        marked [ROM_SIZE];
      int          first, last, step, p, rise;
      logic [63:0] mag;
      for (int v = 0; v < ROM_SIZE; v++) begin
         rom[v]    = '0;
         marked[v] = 1'b0;
      end
      rom[2*TABLE_HALF]    = 16'd8192;
      marked[2*TABLE_HALF] = 1'b1;
      for (int i = 0; i <= MARK_COUNT; i++) begin
         p = TABLE_HALF + int'(scaled_tan(i));
         rom[p]    = 16'(i << 6);
         marked[p] = 1'b1;
      end
      first = TABLE_HALF;
      while (first < 2 * TABLE_HALF) begin
         last = first + 1;
         while (last < 2 * TABLE_HALF && !marked[last]) last++;
         // step truncates toward zero
         rise = int'(rom[last]) - int'(rom[first]);
         mag  = udiv64(64'((rise < 0) ? -rise : rise), 64'(last - first));
         step = (rise < 0) ? -int'(mag) : int'(mag);
         for (int v = first + 1; v < last; v++) rom[v] = 16'(int'(rom[v-1]) + step);
         first = last;
      end
      rom[0]            = 16'd57343;
      rom[2*TABLE_HALF] = 16'd8192;
      for (int v = 0; v < TABLE_HALF; v++) rom[v] = 16'hFFFF - rom[2*TABLE_HALF - v];
      return rom;
   endfunction

endpackage

FILE: rtl/octant_table_atan2_unit.sv
// Top level of the octant table atan2 unit: prep stage, divider cell row, table lookup.
// Registered stages from the start transfer to the rsp_valid strobe (prep stage,
//   32 division cells, index stage, table read, base add).
// Throughput: one item per cycle; busy stays low, each cell moves its item on every cycle.
// Reset: synchronous, active high; clears all valid bits, the table is constant.
module octant_table_atan2_unit
   import otl_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req,
   output logic    rsp_valid,
   output rsp_type rsp
);

   cell_type chain [COORD_BITS+1];

   assign busy = 1'b0;

   otl_prep u_prep (
      .clock (clock),
      .reset (reset),
      .take  (start),
      .req   (req),
      .head  (chain[0])
   );

   for (genvar g = 0; g < COORD_BITS; g++) begin : g_cell
      otl_div_cell u_cell (
         .clock (clock),
         .reset (reset),
         .prev  (chain[g]),
         .next  (chain[g+1])
      );
   end

   otl_lookup u_lookup (
      .clock     (clock),
      .reset     (reset),
      .tail      (chain[COORD_BITS]),
      .rsp_valid (rsp_valid),
      .rsp       (rsp)
   );

endmodule

FILE: rtl/otl_prep.sv
// Sector selection, numerator magnitude and scaled divisor; feeds the divider chain.
module otl_prep
   import otl_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     take,
   input  req_type  req,
   output cell_type head
);

   logic signed [COORD_BITS:0] x, y, nx, ny, num, major;
   logic [COORD_BITS:0]        num_mag, maj_mag, maj_up;
   logic [1:0]                 quad;
   logic [DIV_W-1:0]           dm;
   cell_type                   head_ff, head_in;

   always_comb begin
      x  = {req.coord_x[COORD_BITS-1], req.coord_x};
      y  = {req.coord_y[COORD_BITS-1], req.coord_y};
      nx = -x;
      ny = -y;
      if (x > y) begin
         if (x > ny) begin
            quad = QUAD_EAST;  num = y;  major = x;
         end else begin
            quad = QUAD_SOUTH; num = nx; major = y;
         end
      end else begin
         if (nx > y) begin
            quad = QUAD_WEST;  num = y;  major = x;
         end else begin
            quad = QUAD_NORTH; num = nx; major = y;
         end
      end
      num_mag = num[COORD_BITS] ? (COORD_BITS+1)'(-num) : num;
      maj_mag = major[COORD_BITS] ? (COORD_BITS+1)'(-major) : major;
      // negative major rounds toward minus infinity, i.e. its magnitude rounds up
      maj_up  = maj_mag + (COORD_BITS+1)'(TABLE_HALF - 1);
      dm = major[COORD_BITS] ? DIV_W'(maj_up >> HALF_SHIFT) : DIV_W'(maj_mag >> HALF_SHIFT);

      head_in.valid     = take;
      head_in.meta.quad = quad;
      head_in.meta.neg  = num[COORD_BITS] ^ major[COORD_BITS];
      head_in.meta.zero = (dm == '0);
      head_in.rem       = '0;
      head_in.divisor   = dm;
      head_in.dividend  = num_mag[COORD_BITS-1:0];
      head_in.quot      = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff.valid <= 1'b0;
      end else begin
         head_ff.valid <= head_in.valid;
      end
      head_ff.meta     <= head_in.meta;
      head_ff.rem      <= head_in.rem;
      head_ff.divisor  <= head_in.divisor;
      head_ff.dividend <= head_in.dividend;
      head_ff.quot     <= head_in.quot;
   end

   assign head = head_ff;

endmodule

FILE: rtl/otl_div_cell.sv
// One restoring-division cell: produces one quotient bit and passes the item on.
module otl_div_cell
   import otl_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  cell_type prev,
   output cell_type next
);

   logic [DIV_W:0] trial, diff;
   logic           fits;
   cell_type       next_ff, next_in;

   always_comb begin
      trial = {prev.rem, prev.dividend[COORD_BITS-1]};
      diff  = trial - {1'b0, prev.divisor};
      fits  = (trial >= {1'b0, prev.divisor});
      next_in          = prev;
      next_in.rem      = fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
      next_in.dividend = {prev.dividend[COORD_BITS-2:0], 1'b0};
      next_in.quot     = {prev.quot[COORD_BITS-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         next_ff.valid <= 1'b0;
      end else begin
         next_ff.valid <= next_in.valid;
      end
      next_ff.meta     <= next_in.meta;
      next_ff.rem      <= next_in.rem;
      next_ff.divisor  <= next_in.divisor;
      next_ff.dividend <= next_in.dividend;
      next_ff.quot     <= next_in.quot;
   end

   assign next = next_ff;

endmodule

FILE: rtl/otl_lookup.sv
// Index saturation, tangent-to-angle table read and sector base add.
module otl_lookup
   import otl_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  cell_type tail,
   output logic     rsp_valid,
   output rsp_type  rsp
);

   localparam rom_type ROM = build_rom();

   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             clamp_ff, clamp_in, v1_ff, v2_ff, v3_ff, clamp2_ff;
   meta_type         meta1_ff, meta2_ff;
   logic [ANGLE_W-1:0] rd_ff;
   logic [ANGLE_W-1:0] base;
   rsp_type          rsp_ff, rsp_in;

   always_comb begin
      clamp_in = !tail.meta.zero && (tail.quot > COORD_BITS'(TABLE_HALF));
      if (tail.meta.zero) begin
         idx_in = '0;
      end else if (clamp_in) begin
         idx_in = tail.meta.neg ? IDX_W'(0) : IDX_W'(2 * TABLE_HALF);
      end else if (tail.meta.neg) begin
         idx_in = IDX_W'(TABLE_HALF) - tail.quot[IDX_W-1:0];
      end else begin
         idx_in = IDX_W'(TABLE_HALF) + tail.quot[IDX_W-1:0];
      end
   end

   always_comb begin
      base = {meta2_ff.quad, {(ANGLE_W-2){1'b0}}};
      rsp_in.angle          = meta2_ff.zero ? base : rd_ff + base;
      rsp_in.divide_by_zero = meta2_ff.zero;
      rsp_in.index_clamped  = clamp2_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= tail.valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
      idx_ff    <= idx_in;
      clamp_ff  <= clamp_in;
      meta1_ff  <= tail.meta;
      rd_ff     <= ROM[idx_ff];
      meta2_ff  <= meta1_ff;
      clamp2_ff <= clamp_ff;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid = v3_ff;
   assign rsp       = rsp_ff;

endmodule

FILE: rtl/otl_checker.sv
// Port-level checks for the atan2 unit, bound to the top level.
module otl_checker
   import otl_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input req_type req,
   input logic    rsp_valid,
   input rsp_type rsp
);

   a_latency : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LATENCY rsp_valid)
      else $error("result missing after transfer");

   a_no_orphan : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LATENCY))
      else $error("result without transfer");

   a_zero_flags : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp.divide_by_zero) |->
         (!rsp.index_clamped && rsp.angle[ANGLE_W-3:0] == '0))
      else $error("zero divisor result not a sector base");

   a_never_busy : assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("busy raised");

endmodule

bind octant_table_atan2_unit otl_checker u_otl_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req       (req),
   .rsp_valid (rsp_valid),
   .rsp       (rsp)
);

FILE: tb/tb_octant_table_atan2_unit.sv
// Self-checking testbench for the octant table atan2 unit: random bursts, predicted angles.
module tb_octant_table_atan2_unit;
   import otl_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int RANDOM_ITEMS   = 1100;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req;
   logic    rsp_valid;
   rsp_type rsp;

   octant_table_atan2_unit i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req(req), .rsp_valid(rsp_valid), .rsp(rsp)
   );

   logic [15:0] angle_lut [ROM_SIZE];
   req_type     coord_queue [$];
   rsp_type     angle_queue [$];
   int          mismatch_count;
   int          sent_count;
   int          seen_count;
   int          zero_count;
   int          clamp_count;
   int          quiet_cycles;
   int          idle_left;
   int          burst_left;

   initial clock = 1'b0;
   always #5 clock = ~clock;

   function automatic logic [63:0] q62_product(logic [63:0] a, logic [63:0] b);
      logic [127:0] wide;
      wide = {64'd0, a} * {64'd0, b};
      return wide[125:62];
   endfunction

   // floor(512 * tan(k*pi/512)) by Taylor series in Q62, capped at the table half
   function automatic int tan_mark(int k);
      logic [63:0] theta, theta_sq, term, sine, cosine, ratio;
      if (k == 0) return 0;
      if (k >= MARK_COUNT) return TABLE_HALF;
      theta    = (PI_Q62 >> 9) * 64'(k);
      theta_sq = q62_product(theta, theta);
      term  = theta;
      sine  = theta;
      for (int n = 1; n <= 14; n++) begin
         term = q62_product(term, theta_sq) / 64'((2 * n) * (2 * n + 1));
         sine = (n % 2 == 1) ? sine - term : sine + term;
      end
      term   = ONE_Q62;
      cosine = ONE_Q62;
      for (int n = 1; n <= 14; n++) begin
         term   = q62_product(term, theta_sq) / 64'((2 * n - 1) * (2 * n));
         cosine = (n % 2 == 1) ? cosine - term : cosine + term;
      end
      cosine = cosine >> 12;
      if (cosine == 64'd0) return TABLE_HALF;
      ratio = (64'(TABLE_HALF) * (sine >> 12)) / cosine;
      return (ratio > 64'(TABLE_HALF)) ? TABLE_HALF : int'(ratio);
   endfunction

   task automatic fill_angle_lut();
      bit has_mark [ROM_SIZE];
      int lo, hi, slope, pos;
      for (int v = 0; v < ROM_SIZE; v++) begin
         angle_lut[v] = '0;
         has_mark[v]  = 1'b0;
      end
      angle_lut[2*TABLE_HALF] = 16'd8192;
      has_mark[2*TABLE_HALF]  = 1'b1;
      for (int k = 0; k <= MARK_COUNT; k++) begin
         pos = TABLE_HALF + tan_mark(k);
         angle_lut[pos] = 16'(k * 64);
         has_mark[pos]  = 1'b1;
      end
      lo = TABLE_HALF;
      while (lo < 2 * TABLE_HALF) begin
         hi = lo + 1;
         while (hi < 2 * TABLE_HALF && !has_mark[hi]) hi++;
         slope = (int'(angle_lut[hi]) - int'(angle_lut[lo])) / (hi - lo);
         for (int v = lo + 1; v < hi; v++) angle_lut[v] = 16'(int'(angle_lut[v-1]) + slope);
         lo = hi;
      end
      angle_lut[0]            = 16'd57343;
      angle_lut[2*TABLE_HALF] = 16'd8192;
      for (int v = 0; v < TABLE_HALF; v++) angle_lut[v] = 16'hFFFF - angle_lut[2*TABLE_HALF - v];
   endtask

   function automatic rsp_type predict_angle(req_type item);
      longint  x, y, num, major, num_mag, divisor, quotient;
      int      lut_idx;
      logic [15:0] sector;
      rsp_type res;
      x = longint'(item.coord_x);
      y = longint'(item.coord_y);
      if (x > y) begin
         if (x > -y) begin sector = 16'd0;     num = y;  major = x; end
         else begin        sector = 16'd49152; num = -x; major = y; end
      end else begin
         if (-x > y) begin sector = 16'd32768; num = y;  major = x; end
         else begin        sector = 16'd16384; num = -x; major = y; end
      end
      num_mag = (num < 0) ? -num : num;
      // negative major rounds toward minus infinity, i.e. magnitude rounds up
      divisor = (major < 0) ? (-major + TABLE_HALF - 1) / TABLE_HALF : major / TABLE_HALF;
      res = '0;
      if (divisor == 0) begin
         res.angle          = sector;
         res.divide_by_zero = 1'b1;
         return res;
      end
      quotient = num_mag / divisor;
      if (quotient > TABLE_HALF) begin
         res.index_clamped = 1'b1;
         lut_idx = ((num < 0) != (major < 0)) ? 0 : 2 * TABLE_HALF;
      end else begin
         lut_idx = ((num < 0) != (major < 0)) ? TABLE_HALF - int'(quotient)
                                              : TABLE_HALF + int'(quotient);
      end
      res.angle = angle_lut[lut_idx] + sector;
      return res;
   endfunction

   function automatic logic signed [31:0] rand_coord();
      int shape;
      int bits;
      shape = $urandom_range(0, 9);
      bits  = $urandom_range(1, 31);
      case (shape)
         0, 1, 2: return $urandom;
         3, 4, 5: return $signed($urandom >> (32 - bits)) * ($urandom_range(0, 1) ? 1 : -1);
         6: return $signed($urandom_range(0, 2000)) - 1000;
         7: return $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
         default: return $signed($urandom >> $urandom_range(0, 31));
      endcase
   endfunction

   task automatic queue_coord(logic signed [31:0] x, logic signed [31:0] y);
      req_type item;
      item.coord_x = x;
      item.coord_y = y;
      coord_queue.push_back(item);
   endtask

   // driver: bursts of random length separated by random gaps
   always @(posedge clock) begin
      logic    next_start;
      req_type next_req;
      next_start = 1'b0;
      next_req   = req;
      if (reset) begin
         idle_left  = 0;
         burst_left = $urandom_range(1, 30);
      end else begin
         if (start && !busy) begin
            angle_queue.push_back(predict_angle(coord_queue.pop_front()));
            sent_count++;
         end
         if (idle_left > 0) begin
            idle_left--;
         end else if (coord_queue.size() > 0) begin
            next_start = 1'b1;
            next_req   = coord_queue[0];
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 40);
               idle_left  = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            end
         end
      end
      start <= next_start;
      req   <= next_req;
   end

   // monitor: every strobe is compared with the oldest expectation
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         seen_count++;
         if (angle_queue.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("unexpected result angle=%0d", rsp.angle);
         end else begin
            want = angle_queue.pop_front();
            if (want.divide_by_zero) zero_count++;
            if (want.index_clamped) clamp_count++;
            if (rsp !== want) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display({"mismatch: expected angle=%0d dz=%0b clamp=%0b, ",
                            "got angle=%0d dz=%0b clamp=%0b"},
                           want.angle, want.divide_by_zero, want.index_clamped,
                           rsp.angle, rsp.divide_by_zero, rsp.index_clamped);
            end
         end
      end
   end

   // watchdog: count cycles with no transfer in either direction
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      logic signed [31:0] d;
      start = 1'b0;
      req   = '0;
      reset = 1'b1;
      mismatch_count = 0;
      sent_count = 0;
      seen_count = 0;
      zero_count = 0;
      clamp_count = 0;
      quiet_cycles = 0;
      fill_angle_lut();

      // extremes, axes, diagonals, zero divisor, clamping and rounding of negative majors
      queue_coord(0, 0);
      queue_coord(32'sh7FFFFFFF, 32'sh7FFFFFFF);
      queue_coord(32'sh80000000, 32'sh80000000);
      queue_coord(32'sh7FFFFFFF, 32'sh80000000);
      queue_coord(32'sh80000000, 32'sh7FFFFFFF);
      queue_coord(32'sh80000000, 0);
      queue_coord(0, 32'sh80000000);
      queue_coord(32'sh7FFFFFFF, 0);
      queue_coord(0, 32'sh7FFFFFFF);
      queue_coord(1000, 0);
      queue_coord(-1000, 0);
      queue_coord(5000, 5000);
      queue_coord(-5000, 5000);
      queue_coord(-5000, -5000);
      queue_coord(5000, -5000);
      queue_coord(511, 3);
      queue_coord(-1, 0);
      queue_coord(600, 599);
      queue_coord(600, -599);
      queue_coord(-600, 599);
      queue_coord(-513, -400);
      queue_coord(100000, 99999);
      queue_coord(-2048, 1);
      queue_coord(1, -2048);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         case ($urandom_range(0, 3))
            0: begin
               // near-diagonal pairs stress sector choice and saturation
               d = $signed($urandom_range(0, 4)) - 2;
               queue_coord(rand_coord(), 0);
               coord_queue[$].coord_y = ($urandom_range(0, 1) ? coord_queue[$].coord_x
                                                              : -coord_queue[$].coord_x) + d;
            end
            default: queue_coord(rand_coord(), rand_coord());
         endcase
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      wait (coord_queue.size() == 0 && angle_queue.size() == 0);
      repeat (2 * LATENCY) @(posedge clock);
      $display("sent %0d coordinate pairs, checked %0d angles", sent_count, seen_count);
      $display("zero divisor cases %0d, clamped index cases %0d, mismatches %0d",
               zero_count, clamp_count, mismatch_count);
      if (mismatch_count == 0 && angle_queue.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
